[hdl/handle_table_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the handle table allocator
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HANDLE_TABLE_ALLOCATOR_DEFINES_SVH
`define HANDLE_TABLE_ALLOCATOR_DEFINES_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define HTA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// antecedent implies consequent in the cycle after it
`define HTA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define HTA_ASSERT_IMP(lbl, ante, cons, msg)
`define HTA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hdl/hta_pkg.sv]
// ----------------------------------------------------------------------------
// Handle table allocator package
// Field widths, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package hta_pkg;

  localparam int MODE_W   = 2;
  localparam int HIDX_W   = 16;
  localparam int OBJ_W    = 32;
  localparam int TAG_W    = 8;
  localparam int STATUS_W = 3;
  localparam int HANDLE_W = 9;

  // bitmap word used by the free search
  localparam int WORD_BITS  = 32;
  localparam int WORD_POS_W = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_OPEN  = 2'd0,
    MODE_CLOSE = 2'd1,
    MODE_GET   = 2'd2
  } hta_mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_RANGE    = 3'd2,
    ST_FREE     = 3'd3,
    ST_MISMATCH = 3'd4
  } hta_status_t;

  typedef enum logic [2:0] {
    S_CLR,   // bitmap clearing pass after reset
    S_IDLE,
    S_SUM,   // search summary of full words
    S_RDW,   // read bitmap word picked by the summary
    S_FIND,  // pick free bit, allocate
    S_RDE,   // read entry for close / get
    S_CHK,   // check entry, free on close
    S_FIN    // hand result to output register
  } hta_state_t;

  typedef struct packed {
    logic                  found;
    logic [WORD_POS_W-1:0] pos;
  } hta_ffz_t;

endpackage

[hdl/hta_if.sv]
// ----------------------------------------------------------------------------
// Handle table allocator channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hta_in_if;
  import hta_pkg::*;

  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [HIDX_W-1:0] handle_index;
  logic [OBJ_W-1:0]  object_value;
  logic [TAG_W-1:0]  type_tag;

  modport source (output valid, output mode, output handle_index,
                  output object_value, output type_tag, input ready);
  modport sink   (input valid, input mode, input handle_index,
                  input object_value, input type_tag, output ready);
endinterface

interface hta_out_if;
  import hta_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [HANDLE_W-1:0] result_handle;
  logic [OBJ_W-1:0]    result_object;
  logic [TAG_W-1:0]    result_tag;

  modport source (output valid, output status, output result_handle,
                  output result_object, output result_tag, input ready);
  modport sink   (input valid, input status, input result_handle,
                  input result_object, input result_tag, output ready);
endinterface

[hdl/hta_ffz.sv]
// ----------------------------------------------------------------------------
// Find first zero
// Shared search unit: lowest clear bit of a 32-bit word.
// ----------------------------------------------------------------------------
module hta_ffz (
  input  logic [hta_pkg::WORD_BITS-1:0] vec,
  output hta_pkg::hta_ffz_t             res
);
  import hta_pkg::*;

  logic [WORD_BITS-1:0]  inv;
  logic [WORD_BITS-1:0]  lowest;
  logic [WORD_POS_W-1:0] pos;

  assign inv    = ~vec;
  assign lowest = inv & (~inv + WORD_BITS'(1));

  // one-hot to binary
  always_comb begin
    pos = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        pos = pos | WORD_POS_W'(i);
      end
    end
  end

  assign res.found = |inv;
  assign res.pos   = pos;

endmodule

[hdl/handle_table_allocator.sv]
// ----------------------------------------------------------------------------
// Handle table allocator
// Path: open S_SUM per chunk, S_RDW, S_FIND, S_FIN; close/get S_RDE, S_CHK,
//   S_FIN; rejects (open zero tag, bad range, bad mode) go right to S_FIN.
// One request at a time; the sequencer walks the single bitmap memory port
//   and the shared find-first-zero unit, and takes requests only in S_IDLE.
// Reset clears control at once, then sweeps the bitmap word by word, with
//   no request taken until it ends.
// ----------------------------------------------------------------------------
`include "handle_table_allocator_defines.svh"

module handle_table_allocator #(
  parameter int ENTRIES  = 512,
  parameter int TAG_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  hta_in_if.sink     in_req,
  hta_out_if.source  out_rsp
);
  import hta_pkg::*;

  // Sizing. Entry in use is tracked in a bitmap of 32-bit words; a flag per
  // word marks it full, so open finds the lowest free entry in two searches.
  localparam int IDX_W     = $clog2(ENTRIES);
  localparam int NW        = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int WIDX_W    = (NW > 1) ? $clog2(NW) : 1;
  localparam int NC        = (NW + WORD_BITS - 1) / WORD_BITS;
  localparam int CIDX_W    = (NC > 1) ? $clog2(NC) : 1;
  localparam int HEXT_W    = WIDX_W + WORD_POS_W;
  localparam int SUMW_W    = CIDX_W + WORD_POS_W;
  localparam int HND_EXT_W = IDX_W + HANDLE_W;
  localparam int TAG_EXT_W = TAG_BITS + TAG_W;
  localparam int LAST_FILL = ENTRIES - (NW - 1) * WORD_BITS;
  // bits of the last word past the table read as permanently in use
  localparam logic [WORD_BITS-1:0] LAST_MASK = (LAST_FILL == WORD_BITS) ? '0 :
    ~((WORD_BITS'(1) << LAST_FILL) - WORD_BITS'(1));

  // Sequencer and request registers
  hta_state_t            state_r, state_nxt;
  hta_mode_t             mode_r;
  logic [IDX_W-1:0]      hidx_r;
  logic [OBJ_W-1:0]      obj_r;
  logic [TAG_BITS-1:0]   tag_r;
  logic [CIDX_W-1:0]     chunk_r;
  logic [WIDX_W-1:0]     word_r;
  logic [WIDX_W-1:0]     clr_r;
  logic [NW-1:0]         full_r;

  // Stores
  logic [WORD_BITS-1:0]  bmap [NW];
  logic [TAG_BITS-1:0]   tags [ENTRIES];
  logic [OBJ_W-1:0]      objs [ENTRIES];
  logic [WORD_BITS-1:0]  rd_word_r;
  logic [TAG_BITS-1:0]   rd_tag_r;
  logic [OBJ_W-1:0]      rd_obj_r;

  // Pending result and output register
  hta_status_t           res_status_r;
  logic [HANDLE_W-1:0]   res_handle_r;
  logic [OBJ_W-1:0]      res_obj_r;
  logic [TAG_W-1:0]      res_tag_r;
  logic                  out_valid_r;
  hta_status_t           out_status_r;
  logic [HANDLE_W-1:0]   out_handle_r;
  logic [OBJ_W-1:0]      out_obj_r;
  logic [TAG_W-1:0]      out_tag_r;

  // Request decode
  logic                  in_acc;
  logic [TAG_EXT_W-1:0]  in_tag_ext;
  logic [TAG_BITS-1:0]   in_tag;
  logic                  in_range_bad;
  hta_mode_t             in_mode;

  assign in_acc       = in_req.valid && in_req.ready;
  assign in_tag_ext   = TAG_EXT_W'(in_req.type_tag);
  assign in_tag       = in_tag_ext[TAG_BITS-1:0];
  assign in_range_bad = in_req.handle_index >= HIDX_W'(ENTRIES);
  assign in_mode      = hta_mode_t'(in_req.mode);

  // Handle split into bitmap word and bit
  logic [HEXT_W-1:0]     hidx_ext;
  logic [WIDX_W-1:0]     h_word;
  logic [WORD_POS_W-1:0] h_bit;
  logic [WORD_BITS-1:0]  h_bit_mask;
  logic                  in_use;

  assign hidx_ext   = HEXT_W'(hidx_r);
  assign h_word     = hidx_ext[HEXT_W-1:WORD_POS_W];
  assign h_bit      = hidx_ext[WORD_POS_W-1:0];
  assign h_bit_mask = WORD_BITS'(1) << h_bit;
  assign in_use     = |(rd_word_r & h_bit_mask);

  // Summary flags padded to whole chunks; padding reads as full
  logic [WORD_BITS-1:0]  sum_chunks [NC];

  for (genvar c = 0; c < NC; c++) begin : g_chunk
    for (genvar b = 0; b < WORD_BITS; b++) begin : g_bit
      if (c * WORD_BITS + b < NW) begin : g_flag
        assign sum_chunks[c][b] = full_r[c * WORD_BITS + b];
      end else begin : g_pad
        assign sum_chunks[c][b] = 1'b1;
      end
    end
  end

  // Shared find-first-zero unit: summary chunk in S_SUM, bitmap word otherwise
  logic [WORD_BITS-1:0]  cur_mask;
  logic [WORD_BITS-1:0]  ffz_in;
  hta_ffz_t              ffz_res;

  assign cur_mask = (word_r == WIDX_W'(NW - 1)) ? LAST_MASK : '0;
  assign ffz_in   = (state_r == S_SUM) ? sum_chunks[chunk_r] : (rd_word_r | cur_mask);

  hta_ffz u_ffz (
    .vec (ffz_in),
    .res (ffz_res)
  );

  // Allocation arithmetic
  logic [SUMW_W-1:0]     sum_word_ext;
  logic [WIDX_W-1:0]     sum_word;
  logic [HEXT_W-1:0]     ent_ext;
  logic [IDX_W-1:0]      new_entry;
  logic [HND_EXT_W-1:0]  new_handle_ext;
  logic [WORD_BITS-1:0]  set_word;
  logic                  word_now_full;

  assign sum_word_ext   = {chunk_r, ffz_res.pos};
  assign sum_word       = sum_word_ext[WIDX_W-1:0];
  assign ent_ext        = {word_r, ffz_res.pos};
  assign new_entry      = ent_ext[IDX_W-1:0];
  assign new_handle_ext = HND_EXT_W'(new_entry);
  assign set_word       = rd_word_r | (WORD_BITS'(1) << ffz_res.pos);
  assign word_now_full  = &(set_word | cur_mask);

  // Close / get check
  logic [TAG_EXT_W-1:0]  rd_tag_ext;
  hta_status_t           chk_status;
  logic                  chk_ok;
  logic                  close_ok;

  assign rd_tag_ext  = TAG_EXT_W'(rd_tag_r);

  always_comb begin
    if (mode_r == MODE_CLOSE) begin
      chk_status = in_use ? ST_OK : ST_FREE;
    end else if (tag_r == '0 || !in_use) begin
      chk_status = ST_FREE;
    end else if (rd_tag_r != tag_r) begin
      chk_status = ST_MISMATCH;
    end else begin
      chk_status = ST_OK;
    end
  end

  assign chk_ok   = chk_status == ST_OK;
  assign close_ok = (mode_r == MODE_CLOSE) && in_use;

  // Next state
  logic out_free;
  assign out_free = !out_valid_r || out_rsp.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLR: begin
        if (clr_r == WIDX_W'(NW - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_mode)
            MODE_OPEN:  state_nxt = (in_tag == '0) ? S_FIN : S_SUM;
            MODE_CLOSE,
            MODE_GET:   state_nxt = in_range_bad ? S_FIN : S_RDE;
            default:    state_nxt = S_FIN;
          endcase
        end
      end
      S_SUM: begin
        if (ffz_res.found) begin
          state_nxt = S_RDW;
        end else if (chunk_r == CIDX_W'(NC - 1)) begin
          state_nxt = S_FIN;
        end
      end
      S_RDW:  state_nxt = S_FIND;
      S_FIND: state_nxt = S_FIN;
      S_RDE:  state_nxt = S_CHK;
      S_CHK:  state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: handshake and store controls
  logic                  bm_we;
  logic [WIDX_W-1:0]     bm_waddr;
  logic [WORD_BITS-1:0]  bm_wdata;
  logic [WIDX_W-1:0]     bm_raddr;
  logic                  ent_we;
  logic                  out_load;

  always_comb begin
    bm_we    = 1'b0;
    bm_waddr = h_word;
    bm_wdata = rd_word_r & ~h_bit_mask;
    ent_we   = 1'b0;
    bm_raddr = (state_r == S_RDW) ? word_r : h_word;
    out_load = (state_r == S_FIN) && out_free;
    unique case (state_r)
      S_CLR: begin
        bm_we    = 1'b1;
        bm_waddr = clr_r;
        bm_wdata = '0;
      end
      S_FIND: begin
        bm_we    = 1'b1;
        bm_waddr = word_r;
        bm_wdata = set_word;
        ent_we   = 1'b1;
      end
      S_CHK: begin
        bm_we = close_ok;
      end
      default: begin
      end
    endcase
  end

  assign in_req.ready = state_r == S_IDLE;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      full_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) clr_r <= clr_r + WIDX_W'(1);
      if (state_r == S_FIND && word_now_full) full_r[word_r] <= 1'b1;
      if (state_r == S_CHK && close_ok)       full_r[h_word] <= 1'b0;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_r       <= in_mode;
          hidx_r       <= in_req.handle_index[IDX_W-1:0];
          obj_r        <= in_req.object_value;
          tag_r        <= in_tag;
          chunk_r      <= '0;
          // early rejects: zero tag on open, else range or unused mode
          res_status_r <= (in_mode == MODE_OPEN) ? ST_FREE : ST_RANGE;
          res_handle_r <= '0;
          res_obj_r    <= '0;
          res_tag_r    <= '0;
        end
      end
      S_SUM: begin
        if (ffz_res.found) begin
          word_r <= sum_word;
        end else if (chunk_r == CIDX_W'(NC - 1)) begin
          res_status_r <= ST_FULL;
        end else begin
          chunk_r <= chunk_r + CIDX_W'(1);
        end
      end
      S_FIND: begin
        res_status_r <= ST_OK;
        res_handle_r <= new_handle_ext[HANDLE_W-1:0];
      end
      S_CHK: begin
        res_status_r <= chk_status;
        res_obj_r    <= chk_ok ? rd_obj_r : '0;
        res_tag_r    <= chk_ok ? rd_tag_ext[TAG_W-1:0] : '0;
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_status_r <= res_status_r;
      out_handle_r <= res_handle_r;
      out_obj_r    <= res_obj_r;
      out_tag_r    <= res_tag_r;
    end
  end

  // Stores: one write and registered reads per cycle
  always_ff @(posedge clk) begin
    if (bm_we) bmap[bm_waddr] <= bm_wdata;
    rd_word_r <= bmap[bm_raddr];
    if (ent_we) begin
      tags[new_entry] <= tag_r;
      objs[new_entry] <= obj_r;
    end
    rd_tag_r <= tags[hidx_r];
    rd_obj_r <= objs[hidx_r];
  end

  assign out_rsp.valid         = out_valid_r;
  assign out_rsp.status        = out_status_r;
  assign out_rsp.result_handle = out_handle_r;
  assign out_rsp.result_object = out_obj_r;
  assign out_rsp.result_tag    = out_tag_r;

  // Checks
  `HTA_ASSERT_NEXT(a_busy_after_req, in_acc, !in_req.ready, "ready after accepted request")
  `HTA_ASSERT_IMP(a_rsp_from_fin, $rose(out_valid_r), $past(state_r) == S_FIN, "response not from finish")
  `HTA_ASSERT_IMP(a_handle_only_ok, out_valid_r && out_handle_r != '0, out_status_r == ST_OK, "handle on failed request")
  `HTA_ASSERT_IMP(a_open_no_object, out_valid_r && out_handle_r != '0, out_obj_r == '0 && out_tag_r == '0, "open returned object")

endmodule

[sim/hta_table_checker.sv]
// ----------------------------------------------------------------------------
// Handle table response checker
// Watches both channels of the handle table. Each accepted request updates a
// shadow table and queues its expected response. Each accepted response is
// compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module hta_table_checker #(
  parameter int ENTRIES  = 512,
  parameter int TAG_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  hta_in_if    req_mon,
  hta_out_if   rsp_mon,
  output int   pending_count,
  output int   fail_count
);
  import hta_pkg::*;

  typedef struct packed {
    hta_status_t         status;
    logic [HANDLE_W-1:0] handle;
    logic [OBJ_W-1:0]    obj_word;
    logic [TAG_W-1:0]    tag;
  } table_rsp_t;

  localparam logic [TAG_W-1:0] TAG_MASK = TAG_W'((1 << TAG_BITS) - 1);

  logic [TAG_W-1:0] shadow_tags    [ENTRIES];
  logic [OBJ_W-1:0] shadow_objects [ENTRIES];
  table_rsp_t       expected_rsp_q [$];
  int               rsp_seen;

  // Shadow of the table: applies one request, returns the response it earns.
  function automatic table_rsp_t apply_request(logic [MODE_W-1:0] mode,
                                               logic [HIDX_W-1:0] idx,
                                               logic [OBJ_W-1:0]  obj,
                                               logic [TAG_W-1:0]  tag);
    table_rsp_t       rsp;
    logic [TAG_W-1:0] key;
    int               slot;
    rsp        = '0;
    rsp.status = ST_RANGE;
    key        = tag & TAG_MASK;
    slot       = -1;
    if (mode == MODE_OPEN) begin
      if (key == '0) begin
        rsp.status = ST_FREE;
      end else begin
        for (int i = 0; i < ENTRIES && slot < 0; i++)
          if (shadow_tags[i] == '0) slot = i;
        if (slot < 0) begin
          rsp.status = ST_FULL;
        end else begin
          shadow_tags[slot]    = key;
          shadow_objects[slot] = obj;
          rsp.status           = ST_OK;
          rsp.handle           = HANDLE_W'(slot);
        end
      end
    end else if ((mode == MODE_CLOSE || mode == MODE_GET) && idx < ENTRIES) begin
      if (shadow_tags[idx] == '0 || (mode == MODE_GET && key == '0)) begin
        rsp.status = ST_FREE;
      end else if (mode == MODE_CLOSE) begin
        rsp.status       = ST_OK;
        rsp.obj_word     = shadow_objects[idx];
        rsp.tag          = shadow_tags[idx];
        shadow_tags[idx] = '0;
      end else if (shadow_tags[idx] != key) begin
        rsp.status = ST_MISMATCH;
      end else begin
        rsp.status   = ST_OK;
        rsp.obj_word = shadow_objects[idx];
        rsp.tag      = key;
      end
    end
    return rsp;
  endfunction

  task automatic report_mismatch(string what, logic [OBJ_W-1:0] got,
                                 logic [OBJ_W-1:0] want);
    $display("[%0t] response %0d: %s got 0x%0h, expected 0x%0h",
             $time, rsp_seen, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin : monitor
    table_rsp_t want;
    if (!rst_n) begin
      foreach (shadow_tags[i]) begin
        shadow_tags[i]    = '0;
        shadow_objects[i] = '0;
      end
      expected_rsp_q.delete();
      rsp_seen      = 0;
      fail_count    = 0;
      pending_count <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected response, status", OBJ_W'(rsp_mon.status), '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (rsp_mon.status !== want.status)
            report_mismatch("status", OBJ_W'(rsp_mon.status), OBJ_W'(want.status));
          if (rsp_mon.result_handle !== want.handle)
            report_mismatch("handle", OBJ_W'(rsp_mon.result_handle), OBJ_W'(want.handle));
          if (rsp_mon.result_object !== want.obj_word)
            report_mismatch("object", rsp_mon.result_object, want.obj_word);
          if (rsp_mon.result_tag !== want.tag)
            report_mismatch("tag", OBJ_W'(rsp_mon.result_tag), OBJ_W'(want.tag));
        end
        rsp_seen++;
      end
      if (req_mon.valid && req_mon.ready)
        expected_rsp_q.push_back(apply_request(req_mon.mode, req_mon.handle_index,
                                               req_mon.object_value, req_mon.type_tag));
      pending_count <= expected_rsp_q.size();
    end
  end

endmodule

[sim/tb_handle_table_allocator.sv]
// ----------------------------------------------------------------------------
// Handle table allocator testbench
// Directed requests hit every operation and every rejection path short of a
// full table, then a random load fills the table to capacity, drains it with
// scattered closes and runs a mixed load. Both channels idle at random; the
// checker alongside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_handle_table_allocator;
  import hta_pkg::*;

  localparam int ENTRIES       = 512;
  localparam int TAG_BITS      = 8;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int CYCLE_LIMIT   = 400000;  // slowest clean run is well under this
  localparam int SETTLE_CYCLES = 32;      // covers the longest open latency
  localparam int IDLE_PCT      = 22;
  // the one mode code the block must refuse
  localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

  // shape of the random load: open-heavy, close-heavy, then mixed
  typedef enum {PH_FILL, PH_DRAIN, PH_MIXED} load_phase_t;

  logic        clk       = 1'b0;
  logic        rst_n;
  logic        rsp_ready = 1'b0;
  logic        calm      = 1'b0;   // high: neither side idles
  int unsigned cycle_count = 0;
  int          pending_count;
  int          fail_count;
  int          sent_by_mode [4] = '{default: 0};

  hta_in_if  req_ch ();
  hta_out_if rsp_ch ();

  assign rsp_ch.ready = rsp_ready;

  handle_table_allocator #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (req_ch),
    .out_rsp (rsp_ch)
  );

  hta_table_checker #(
    .ENTRIES  (ENTRIES),
    .TAG_BITS (TAG_BITS)
  ) checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_mon       (req_ch),
    .rsp_mon       (rsp_ch),
    .pending_count (pending_count),
    .fail_count    (fail_count)
  );

  // 20-unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // response side stalls on its own schedule, except in the quiet stretch
  always @(posedge clk) begin
    rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[%0t] watchdog: %0d cycles, %0d responses outstanding",
               $time, cycle_count, pending_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Present one request and hold it until the block takes it. An optional
  // idle gap comes first; valid stays high straight into the next request
  // when there is no gap.
  task automatic send_request(input logic [MODE_W-1:0] mode,
                              input logic [HIDX_W-1:0] idx,
                              input logic [OBJ_W-1:0]  obj,
                              input logic [TAG_W-1:0]  tag);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.mode         <= mode;
    req_ch.handle_index <= idx;
    req_ch.object_value <= obj;
    req_ch.type_tag     <= tag;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    sent_by_mode[mode]++;
  endtask

  // One random request. Tags come mostly from a small pool so that gets
  // hit matching and mismatching tags alike; outside the drain phase, indices
  // stay low where the first-free allocator packs live handles, with some
  // reaching past the table and across the full 16-bit range.
  task automatic send_random(input load_phase_t ph);
    int                r;
    int                open_lim, close_lim, get_lim;
    logic [MODE_W-1:0] mode;
    logic [HIDX_W-1:0] idx;
    logic [OBJ_W-1:0]  obj;
    logic [TAG_W-1:0]  tag;
    case (ph)
      PH_FILL: begin
        open_lim = 88; close_lim = 92; get_lim = 98;
      end
      PH_DRAIN: begin
        open_lim = 10; close_lim = 75; get_lim = 95;
      end
      default: begin
        open_lim = 35; close_lim = 65; get_lim = 95;
      end
    endcase
    r = $urandom_range(99);
    if (r < open_lim)       mode = MODE_OPEN;
    else if (r < close_lim) mode = MODE_CLOSE;
    else if (r < get_lim)   mode = MODE_GET;
    else                    mode = MODE_UNUSED;

    r = $urandom_range(99);
    if (r < 60)
      idx = (ph == PH_DRAIN) ? HIDX_W'($urandom_range(ENTRIES - 1))
                             : HIDX_W'($urandom_range(63));
    else if (r < 82) idx = HIDX_W'($urandom_range(ENTRIES - 1));
    else if (r < 92) idx = HIDX_W'($urandom_range(65535));
    else if (r < 96) idx = HIDX_W'(ENTRIES - 1);
    else if (r < 98) idx = HIDX_W'(ENTRIES);
    else             idx = '1;

    r = $urandom_range(99);
    if (r < 8)       tag = '0;
    else if (r < 68) tag = TAG_W'($urandom_range(4, 1));
    else if (r < 95) tag = TAG_W'($urandom_range(255, 1));
    else             tag = '1;

    r = $urandom_range(99);
    if (r < 5)       obj = '0;
    else if (r < 10) obj = '1;
    else             obj = $urandom;

    send_request(mode, idx, obj, tag);
  endtask

  initial begin : stimulus
    load_phase_t ph;
    rst_n               <= 1'b0;
    req_ch.valid        <= 1'b0;
    req_ch.mode         <= '0;
    req_ch.handle_index <= '0;
    req_ch.object_value <= '0;
    req_ch.type_tag     <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed: empty table, rejections, extremes, reuse ---
    send_request(MODE_GET,    16'd0,    32'd0,          8'h05); // get on free entry
    send_request(MODE_CLOSE,  16'd0,    32'd0,          8'h00); // close of free entry
    send_request(MODE_OPEN,   16'd0,    32'h0000_1234,  8'h00); // open, zero tag
    send_request(MODE_OPEN,   16'hFFFF, 32'hFFFF_FFFF,  8'hFF); // -> handle 0
    send_request(MODE_OPEN,   16'd0,    32'h0000_0000,  8'h01); // -> handle 1
    send_request(MODE_OPEN,   16'd7,    32'hA5A5_5A5A,  8'h80); // -> handle 2
    send_request(MODE_GET,    16'd0,    32'd0,          8'hFF); // match
    send_request(MODE_GET,    16'd0,    32'd0,          8'h01); // tag mismatch
    send_request(MODE_GET,    16'd0,    32'd0,          8'h00); // zero tag query
    send_request(MODE_GET,    16'd1,    32'hFFFF_FFFF,  8'h01); // object of zero
    send_request(MODE_GET,    16'(ENTRIES - 1), 32'd0,  8'h01); // last entry, free
    send_request(MODE_GET,    16'(ENTRIES),     32'd0,  8'h01); // first index past
    send_request(MODE_CLOSE,  16'hFFFF, 32'd0,          8'h00); // far out of range
    send_request(MODE_UNUSED, 16'd0,    32'd0,          8'hFF); // unused mode
    send_request(MODE_UNUSED, 16'hFFFF, 32'hFFFF_FFFF,  8'hFF);
    send_request(MODE_CLOSE,  16'(ENTRIES - 1), 32'd0,  8'h00); // last entry, free
    send_request(MODE_CLOSE,  16'd0,    32'd0,          8'h00); // returns obj + tag
    send_request(MODE_CLOSE,  16'd0,    32'd0,          8'h00); // double close
    send_request(MODE_GET,    16'd0,    32'd0,          8'hFF); // stale handle
    send_request(MODE_OPEN,   16'd0,    32'h5555_AAAA,  8'h7F); // reuses handle 0
    send_request(MODE_OPEN,   16'd0,    32'h8000_0001,  8'h03); // -> handle 3
    send_request(MODE_CLOSE,  16'd1,    32'd0,          8'h00);
    send_request(MODE_GET,    16'd1,    32'd0,          8'h01); // freed entry

    // --- random: fill past full, drain with holes, then mixed traffic ---
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 730)  calm <= 1'b1;   // quiet stretch for both sides
      if (n == 1000) calm <= 1'b0;
      if (n < 720)       ph = PH_FILL;
      else if (n < 1200) ph = PH_DRAIN;
      else               ph = PH_MIXED;
      send_random(ph);
    end
    req_ch.valid <= 1'b0;

    // drain outstanding responses, then a margin for strays
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("requests accepted: %0d open, %0d close, %0d get, %0d unused mode",
             sent_by_mode[MODE_OPEN], sent_by_mode[MODE_CLOSE],
             sent_by_mode[MODE_GET], sent_by_mode[MODE_UNUSED]);
    $display("load ran from empty to full table and back, %0d cycles, %0d mismatches",
             cycle_count, fail_count);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
